>>> rtl/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types, register indexes and the control program of the modular
// exponentiation sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rme_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = 1'd1;

    // width of the ports, independent of the datapath width
    localparam int PORT_BITS = 64;

    // program counter
    localparam int PC_BITS = 4;
    typedef logic [PC_BITS-1:0] pc_t;

    // step operation
    typedef enum logic [1:0] {
        OP_NOP,
        OP_MUL,
        OP_SHIFT,
        OP_EMIT
    } op_t;

    // jump condition, tested when the step completes
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_N_ZERO,
        C_E_ZERO,
        C_E_LSB_CLR
    } cond_t;

    // first multiplier operand (the second is always the base)
    typedef enum logic [1:0] {
        A_ONE,
        A_ACC,
        A_BASE
    } asel_t;

    // destination of the product
    typedef enum logic {
        D_BASE,
        D_ACC
    } dst_t;

    // result selection of an emit step
    typedef enum logic [1:0] {
        O_ERR,
        O_ONE,
        O_ACC
    } osel_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
        asel_t a_sel;
        dst_t  dst;
        osel_t out_sel;
    } ctrl_word_t;

    // program addresses
    localparam pc_t PC_START = 4'd0;
    localparam pc_t PC_CHK_E = 4'd1;
    localparam pc_t PC_RED   = 4'd2;
    localparam pc_t PC_LOOP  = 4'd3;
    localparam pc_t PC_MULT  = 4'd4;
    localparam pc_t PC_SHIFT = 4'd5;
    localparam pc_t PC_TEST  = 4'd6;
    localparam pc_t PC_SQR   = 4'd7;
    localparam pc_t PC_ERR   = 4'd8;
    localparam pc_t PC_ONE   = 4'd9;
    localparam pc_t PC_OUT   = 4'd10;

    // control program rom
    function automatic ctrl_word_t rom_word(input pc_t pc);
        ctrl_word_t w;
        w.op      = OP_NOP;
        w.cond    = C_NEVER;
        w.target  = PC_START;
        w.a_sel   = A_ONE;
        w.dst     = D_BASE;
        w.out_sel = O_ACC;
        case (pc)
            PC_START: begin
                w.cond   = C_N_ZERO;
                w.target = PC_ERR;
            end
            PC_CHK_E: begin
                w.cond   = C_E_ZERO;
                w.target = PC_ONE;
            end
            PC_RED: begin
                // base = message mod n, as one_mod * message
                w.op    = OP_MUL;
                w.a_sel = A_ONE;
                w.dst   = D_BASE;
            end
            PC_LOOP: begin
                w.cond   = C_E_LSB_CLR;
                w.target = PC_SHIFT;
            end
            PC_MULT: begin
                w.op    = OP_MUL;
                w.a_sel = A_ACC;
                w.dst   = D_ACC;
            end
            PC_SHIFT: begin
                w.op = OP_SHIFT;
            end
            PC_TEST: begin
                w.cond   = C_E_ZERO;
                w.target = PC_OUT;
            end
            PC_SQR: begin
                w.op     = OP_MUL;
                w.a_sel  = A_BASE;
                w.dst    = D_BASE;
                w.cond   = C_ALWAYS;
                w.target = PC_LOOP;
            end
            PC_ERR: begin
                w.op      = OP_EMIT;
                w.out_sel = O_ERR;
            end
            PC_ONE: begin
                w.op      = OP_EMIT;
                w.out_sel = O_ONE;
            end
            PC_OUT: begin
                w.op      = OP_EMIT;
                w.out_sel = O_ACC;
            end
            default: begin
                w.op      = OP_EMIT;
                w.out_sel = O_ERR;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rme_mulmod.sv
// ----------------------------------------------------------------------------
// rme_mulmod
// Modular multiplier: product = (a * b) mod n by MSB-first shift-and-add,
// one bit of b per cycle. Requires a < n; b may take any value.
// ----------------------------------------------------------------------------
`default_nettype none

module rme_mulmod #(
    parameter int WORD_BITS = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [WORD_BITS-1:0] a,
    input  wire logic [WORD_BITS-1:0] b,
    input  wire logic [WORD_BITS-1:0] n,
    output logic                      done,
    output logic [WORD_BITS-1:0]      product
);

    localparam int CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] a_reg, a_next;
    logic [WORD_BITS-1:0] b_reg, b_next;

    logic [WORD_BITS+1:0] sum;
    logic [WORD_BITS+1:0] n1;
    logic [WORD_BITS+1:0] n2;
    logic [WORD_BITS+1:0] red;

    // one step: acc = (2 * acc + bit * a) mod n, sum stays below 3n
    always_comb
    begin
        n1  = {2'b00, n};
        n2  = {1'b0, n, 1'b0};
        sum = {1'b0, acc_reg, 1'b0}
            + {2'b00, (b_reg[WORD_BITS-1] ? a_reg : {WORD_BITS{1'b0}})};
        if (sum >= n2)
        begin
            red = sum - n2;
        end
        else if (sum >= n1)
        begin
            red = sum - n1;
        end
        else
        begin
            red = sum;
        end
    end

    // step control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(WORD_BITS - 1);
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
        end
        else if (busy_reg)
        begin
            acc_next = red[WORD_BITS-1:0];
            b_next   = b_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

>>> rtl/rsa_modular_exponentiation.sv
// Run time depends on the operands: a zero modulus or a zero exponent gives a
// result with no product; otherwise each exponent bit takes one or two
// products of the bit-serial modular multiplier.
// Throughput: one message at a time; the next is taken once the result is
// placed in the output register. Reset clears control and the key registers.
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation
// Right-to-left square-and-multiply modular exponentiation, run by a small
// microcoded sequencer over a shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_modular_exponentiation
    import rme_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [PORT_BITS-1:0]      cfg_data,
    // input
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [PORT_BITS-1:0]      message,
    // output
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [PORT_BITS-1:0]           value,
    output logic                           modulus_error
);

    logic [WORD_BITS-1:0] exponent_reg;
    logic [WORD_BITS-1:0] modulus_reg;

    logic                 busy_reg, busy_next;
    logic                 issued_reg, issued_next;
    pc_t                  pc_reg, pc_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0] base_reg, base_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] e_reg, e_next;
    logic [WORD_BITS-1:0] value_reg, value_next;
    logic                 err_reg, err_next;

    ctrl_word_t           ctrl;
    logic [WORD_BITS-1:0] one_mod;
    logic [WORD_BITS-1:0] mul_a;
    logic                 mul_start;
    logic                 mul_done;
    logic [WORD_BITS-1:0] mul_product;
    logic                 step_done;
    logic                 take_jump;

    // key registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= '0;
            modulus_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_EXPONENT: exponent_reg <= cfg_data[WORD_BITS-1:0];
                REG_MODULUS:  modulus_reg  <= cfg_data[WORD_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // 1 reduced modulo n (a zero n yields 1 here, but that run ends in the error result)
    assign one_mod = (modulus_reg == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

    // control word of the current step
    assign ctrl = rom_word(pc_reg);

    // first multiplier operand
    always_comb
    begin
        case (ctrl.a_sel)
            A_ONE:   mul_a = one_mod;
            A_ACC:   mul_a = acc_reg;
            A_BASE:  mul_a = base_reg;
            default: mul_a = one_mod;
        endcase
    end

    // jump condition
    always_comb
    begin
        case (ctrl.cond)
            C_NEVER:     take_jump = 1'b0;
            C_ALWAYS:    take_jump = 1'b1;
            C_N_ZERO:    take_jump = (modulus_reg == '0);
            C_E_ZERO:    take_jump = (e_reg == '0);
            C_E_LSB_CLR: take_jump = !e_reg[0];
            default:     take_jump = 1'b0;
        endcase
    end

    // sequencer
    always_comb
    begin
        busy_next      = busy_reg;
        issued_next    = issued_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        e_next         = e_reg;
        value_next     = value_reg;
        err_next       = err_reg;
        mul_start      = 1'b0;
        step_done      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_valid && in_ready)
        begin
            busy_next   = 1'b1;
            issued_next = 1'b0;
            pc_next     = PC_START;
            base_next   = message[WORD_BITS-1:0];
            e_next      = exponent_reg;
            acc_next    = one_mod;
        end
        else if (busy_reg)
        begin
            case (ctrl.op)
                OP_NOP:
                begin
                    step_done = 1'b1;
                end
                OP_MUL:
                begin
                    if (mul_done)
                    begin
                        step_done   = 1'b1;
                        issued_next = 1'b0;
                        if (ctrl.dst == D_ACC)
                        begin
                            acc_next = mul_product;
                        end
                        else
                        begin
                            base_next = mul_product;
                        end
                    end
                    else if (!issued_reg)
                    begin
                        mul_start   = 1'b1;
                        issued_next = 1'b1;
                    end
                end
                OP_SHIFT:
                begin
                    e_next    = e_reg >> 1;
                    step_done = 1'b1;
                end
                OP_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_next = 1'b1;
                        busy_next      = 1'b0;
                        step_done      = 1'b1;
                        case (ctrl.out_sel)
                            O_ERR:
                            begin
                                value_next = '0;
                                err_next   = 1'b1;
                            end
                            O_ONE:
                            begin
                                value_next = WORD_BITS'(1);
                                err_next   = 1'b0;
                            end
                            O_ACC:
                            begin
                                value_next = acc_reg;
                                err_next   = 1'b0;
                            end
                            default:
                            begin
                                value_next = '0;
                                err_next   = 1'b1;
                            end
                        endcase
                    end
                end
                default:
                begin
                    step_done = 1'b1;
                end
            endcase

            if (step_done)
            begin
                pc_next = take_jump ? ctrl.target : pc_reg + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            issued_reg    <= 1'b0;
            pc_reg        <= PC_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            issued_reg    <= issued_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        acc_reg   <= acc_next;
        e_reg     <= e_next;
        value_reg <= value_next;
        err_reg   <= err_next;
    end

    // shared modular multiplier, second operand is always the base
    rme_mulmod #(
        .WORD_BITS (WORD_BITS)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (base_reg),
        .n       (modulus_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    // outputs
    assign in_ready      = !busy_reg;
    assign out_valid     = out_valid_reg;
    assign value         = PORT_BITS'(value_reg);
    assign modulus_error = err_reg;

`ifndef SYNTHESIS
    // an accepted transaction always starts the program
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (busy_reg && pc_reg == PC_START))
        else $error("accepted transaction did not start the sequencer");

    // the sequencer only goes idle by placing a result
    a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> out_valid_reg)
        else $error("sequencer went idle without a result");

    // a product only completes inside a multiply step that issued it
    a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (busy_reg && issued_reg && ctrl.op == OP_MUL))
        else $error("multiplier finished outside a multiply step");

    // a flagged result carries a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && modulus_error) |-> (value == '0))
        else $error("modulus error with nonzero value");
`endif

endmodule

`default_nettype wire
